// ===== sv/i2cmb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmb_pkg
// Shared types and constants of the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cmb_pkg;

	localparam int TpuW   = 16;
	localparam int TmoW   = 8;
	localparam int DelayW = 20;
	localparam int CfgW   = 16;

	localparam logic [TmoW-1:0] AckTimeoutRst = TmoW'(250);
	localparam logic [TpuW-1:0] TicksPerUsRst = TpuW'(1);

	localparam logic CFG_TICKS_PER_US = 1'b0;
	localparam logic CFG_ACK_TIMEOUT  = 1'b1;

	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST_A    = 5'd1,
		PH_ST_B    = 5'd2,
		PH_SP_A    = 5'd3,
		PH_SP_B    = 5'd4,
		PH_WR_SET  = 5'd5,
		PH_WR_HI   = 5'd6,
		PH_WR_LO   = 5'd7,
		PH_AK_REL  = 5'd8,
		PH_AK_HI   = 5'd9,
		PH_AK_POLL = 5'd10,
		PH_RD_LO   = 5'd11,
		PH_RD_HI   = 5'd12,
		PH_RA_SET  = 5'd13,
		PH_RA_HI   = 5'd14
	} phase_t;

	typedef struct packed {
		logic drive;
		logic level;
		logic scl;
	} lines_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
		logic       cmd_rejected;
	} out_item_t;

	function automatic lines_t mk_lines(input logic c, input logic l, input logic d);
		lines_t r;
		r.scl   = c;
		r.level = l;
		r.drive = d;
		return r;
	endfunction

endpackage

// ===== sv/i2c_master_byte_engine.sv =====
`timescale 1ns / 1ps
// A tick beat passes the input register, then the result register.
// Throughput: one tick beat per cycle unless out_ready stalls the result.
// Input register and result register decouple the two channels.
// Reset: bus idle with SCL high and SDA driven high, ticks_per_us 1,
// ack_timeout 250, rx byte and failure flag cleared.
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Tick-driven I2C master: start, stop, byte write with ack poll, byte read.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine
	import i2cmb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output out_item_t       out_data
);

	logic      item_valid;
	in_item_t  item;
	logic      adv;
	out_item_t res;
	logic      out_vld_q;
	out_item_t out_q;

	assign adv = item_valid && (!out_vld_q || out_ready);

	i2cmb_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.take       (adv),
		.item_valid (item_valid),
		.item       (item)
	);

	i2cmb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (adv),
		.item      (item),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

// ===== sv/i2cmb_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmb_in_reg
// Input register: holds one tick beat until the sequencer takes it.
// ----------------------------------------------------------------------------
module i2cmb_in_reg
	import i2cmb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     take,
	output logic     item_valid,
	output in_item_t item
);

	logic     vld_s1;
	in_item_t data_s1;

	assign in_ready   = !vld_s1 || take;
	assign item_valid = vld_s1;
	assign item       = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_data;
		end
	end

endmodule

// ===== sv/i2cmb_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmb_seq
// Bus phase sequencer: configuration, engine state and one-tick step logic.
// ----------------------------------------------------------------------------
module i2cmb_seq
	import i2cmb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [CfgW-1:0] cfg_data,
	input  logic            step,
	input  in_item_t        item,
	output out_item_t       res
);

	logic [TpuW-1:0]   tpu_q;
	logic [TmoW-1:0]   tmo_q;
	phase_t            phase_q, phase_d;
	logic [3:0]        bit_q, bit_d;
	logic [7:0]        shift_q, shift_d;
	logic [DelayW-1:0] delay_q, delay_d;
	logic [7:0]        poll_q, poll_d;
	lines_t            lines_q, lines_d;
	logic              ack_q, ack_d;
	logic [7:0]        rx_q, rx_d;
	logic              fail_q, fail_d;
	logic              done, rej, cmd;
	logic [DelayW-1:0] d1, d2, d4;
	logic [3:0]        bit_inc;
	logic [7:0]        shift_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TicksPerUsRst;
			tmo_q <= AckTimeoutRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TICKS_PER_US: tpu_q <= cfg_data[TpuW-1:0];
				CFG_ACK_TIMEOUT:  tmo_q <= cfg_data[TmoW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		d1 = (tpu_q == '0) ? DelayW'(1) : DelayW'(tpu_q);
		d2 = (tpu_q == '0) ? DelayW'(1) : DelayW'({tpu_q, 1'b0});
		d4 = (tpu_q == '0) ? DelayW'(1) : DelayW'({tpu_q, 2'b00});
		bit_inc  = bit_q + 4'd1;
		shift_sh = {shift_q[6:0], 1'b0};
		case (item.op) inside
			[OP_START:OP_READ]: cmd = 1'b1;
			default:            cmd = 1'b0;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		delay_d = delay_q;
		poll_d  = poll_q;
		lines_d = lines_q;
		ack_d   = ack_q;
		rx_d    = rx_q;
		fail_d  = fail_q;
		done    = 1'b0;
		rej     = 1'b0;
		if (phase_q != PH_IDLE) begin
			rej = cmd;
			if (phase_q == PH_AK_POLL) begin
				if (!item.sda_in) begin
					fail_d  = 1'b0;
					phase_d = PH_IDLE;
					lines_d = mk_lines(1'b0, 1'b1, 1'b0);
					done    = 1'b1;
				end else if (poll_q >= tmo_q) begin
					fail_d  = 1'b1;
					phase_d = PH_SP_A;
					lines_d = mk_lines(1'b0, 1'b0, 1'b1);
					delay_d = d4;
				end else begin
					poll_d = poll_q + 8'd1;
				end
			end else if (phase_q == PH_RD_LO && delay_q <= DelayW'(1)) begin
				phase_d = PH_RD_HI;
				lines_d = mk_lines(1'b1, 1'b1, 1'b0);
				delay_d = d1;
				shift_d = {shift_q[6:0], item.sda_in};
				bit_d   = bit_inc;
			end else if (delay_q <= DelayW'(1)) begin
				unique case (phase_q)
					PH_ST_A: begin
						phase_d = PH_ST_B;
						lines_d = mk_lines(1'b1, 1'b0, 1'b1);
						delay_d = d4;
					end
					PH_ST_B: begin
						phase_d = PH_IDLE;
						lines_d = mk_lines(1'b0, 1'b0, 1'b1);
						done    = 1'b1;
					end
					PH_SP_A: begin
						phase_d = PH_SP_B;
						lines_d = mk_lines(1'b1, 1'b1, 1'b1);
						delay_d = d4;
					end
					PH_SP_B: begin
						phase_d = PH_IDLE;
						lines_d = mk_lines(1'b1, 1'b1, 1'b1);
						done    = 1'b1;
					end
					PH_WR_SET: begin
						phase_d     = PH_WR_HI;
						lines_d.scl = 1'b1;
						delay_d     = d2;
					end
					PH_WR_HI: begin
						phase_d     = PH_WR_LO;
						lines_d.scl = 1'b0;
						delay_d     = d2;
					end
					PH_WR_LO: begin
						shift_d = shift_sh;
						bit_d   = bit_inc;
						if (bit_inc[3]) begin
							phase_d = PH_AK_REL;
							lines_d = mk_lines(1'b0, 1'b1, 1'b0);
							delay_d = d1;
						end else begin
							phase_d = PH_WR_SET;
							lines_d = mk_lines(1'b0, shift_sh[7], 1'b1);
							delay_d = d2;
						end
					end
					PH_AK_REL: begin
						phase_d = PH_AK_HI;
						lines_d = mk_lines(1'b1, 1'b1, 1'b0);
						delay_d = d1;
					end
					PH_AK_HI: begin
						phase_d = PH_AK_POLL;
						poll_d  = '0;
					end
					PH_RD_HI: begin
						if (bit_q[3]) begin
							phase_d = PH_RA_SET;
							lines_d = mk_lines(1'b0, ~ack_q, 1'b1);
						end else begin
							phase_d = PH_RD_LO;
							lines_d = mk_lines(1'b0, 1'b1, 1'b0);
						end
						delay_d = d2;
					end
					PH_RA_SET: begin
						phase_d     = PH_RA_HI;
						lines_d.scl = 1'b1;
						delay_d     = d2;
					end
					PH_RA_HI: begin
						rx_d        = shift_q;
						phase_d     = PH_IDLE;
						lines_d.scl = 1'b0;
						done        = 1'b1;
					end
					default: phase_d = PH_IDLE;
				endcase
			end else begin
				delay_d = delay_q - DelayW'(1);
			end
		end else begin
			unique case (item.op)
				OP_START: begin
					phase_d = PH_ST_A;
					lines_d = mk_lines(1'b1, 1'b1, 1'b1);
					delay_d = d4;
				end
				OP_STOP: begin
					phase_d = PH_SP_A;
					lines_d = mk_lines(1'b0, 1'b0, 1'b1);
					delay_d = d4;
				end
				OP_WRITE: begin
					shift_d = item.tx_byte;
					bit_d   = '0;
					poll_d  = '0;
					phase_d = PH_WR_SET;
					lines_d = mk_lines(1'b0, item.tx_byte[7], 1'b1);
					delay_d = d2;
				end
				OP_READ: begin
					shift_d = '0;
					bit_d   = '0;
					ack_d   = item.send_ack;
					phase_d = PH_RD_LO;
					lines_d = mk_lines(1'b0, 1'b1, 1'b0);
					delay_d = d2;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		res.scl          = lines_d.scl;
		res.sda_level    = lines_d.level;
		res.sda_drive    = lines_d.drive;
		res.busy_res     = (phase_d != PH_IDLE);
		res.done_res     = done;
		res.rx_byte      = rx_d;
		res.ack_failed   = fail_d;
		res.cmd_rejected = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			delay_q <= '0;
			poll_q  <= '0;
			lines_q <= mk_lines(1'b1, 1'b1, 1'b1);
			ack_q   <= 1'b0;
			rx_q    <= '0;
			fail_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			delay_q <= delay_d;
			poll_q  <= poll_d;
			lines_q <= lines_d;
			ack_q   <= ack_d;
			rx_q    <= rx_d;
			fail_q  <= fail_d;
		end
	end

endmodule
